>>> rtl/core/panel_deploy_supervisor_assert.svh
// assertion macros used by the panel deploy supervisor rtl
`ifndef PANEL_DEPLOY_SUPERVISOR_ASSERT_SVH
`define PANEL_DEPLOY_SUPERVISOR_ASSERT_SVH

// property that holds in the same cycle
`define PDS_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("pds check failed");

// property that holds in the next cycle
`define PDS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("pds check failed");

`endif

>>> rtl/core/pds_pkg.sv
// types, codes and reset values of the panel deploy supervisor
package pds_pkg;

  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 24;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [15:0] EmergPowerMaxRst    = 16'd200;
  localparam logic [15:0] DegradedPowerMaxRst = 16'd500;
  localparam logic [2:0]  SelftestTicksRst    = 3'd5;
  localparam logic [7:0]  TravelLimitRst      = 8'd20;
  localparam logic [3:0]  NormalStepRst       = 4'd2;
  localparam logic [3:0]  ReducedStepRst      = 4'd1;
  localparam logic [2:0]  TickMax             = 3'd7;
  localparam logic [7:0]  PosMax              = 8'd255;

  typedef enum logic [2:0] {
    ST_STANDBY = 3'd0,
    ST_SELFTEST = 3'd1,
    ST_FAIL = 3'd2,
    ST_READY = 3'd3,
    ST_MAINT = 3'd4,
    ST_OPER = 3'd5,
    ST_EMERG = 3'd6
  } pds_state_e;

  typedef enum logic [2:0] {
    PM_SAFE = 3'd0,
    PM_CLOSED = 3'd1,
    PM_EXTEND = 3'd2,
    PM_OPEN = 3'd3,
    PM_RETRACT = 3'd4
  } pds_pmode_e;

  typedef enum logic [2:0] {
    EV_NONE = 3'd0,
    EV_CLOSED = 3'd1,
    EV_RETRACT = 3'd2,
    EV_REDUCED = 3'd3,
    EV_SHUTDOWN = 3'd4
  } pds_event_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_EMERG_PMAX = 3'd0,
    CFG_DEGR_PMAX = 3'd1,
    CFG_ST_TICKS = 3'd2,
    CFG_TRAVEL = 3'd3,
    CFG_NORM_STEP = 3'd4,
    CFG_RED_STEP = 3'd5
  } pds_cfg_idx_e;

  typedef struct packed {
    logic                valid;
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;
  } pds_cfg_wr_t;

  typedef struct packed {
    logic [15:0] emergency_power_max;
    logic [15:0] degraded_power_max;
    logic [2:0]  selftest_ticks;
    logic [7:0]  travel_limit;
    logic [3:0]  normal_step;
    logic [3:0]  reduced_step;
  } pds_cfg_t;

  typedef struct packed {
    logic        on_write;
    logic        on_value;
    logic [15:0] supply_power;
    logic        maintenance_switch;
    logic        shutdown_switch;
    logic        panel_request;
  } pds_item_t;

  typedef struct packed {
    logic [2:0] state_code;
    logic [2:0] panel_mode;
    logic [7:0] panel_position;
    logic       reduced_active;
    logic       on_state;
    logic [2:0] event_code;
  } pds_result_t;

endpackage

>>> rtl/core/pds_cfg.sv
// configuration register bank of the panel deploy supervisor
module pds_cfg (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pds_pkg::pds_cfg_wr_t wr_i,
  output pds_pkg::pds_cfg_t   cfg_o
);
  import pds_pkg::*;

  pds_cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_i.valid) begin
      unique case (wr_i.index)
        CFG_EMERG_PMAX: cfg_d.emergency_power_max = wr_i.data;
        CFG_DEGR_PMAX:  cfg_d.degraded_power_max = wr_i.data;
        CFG_ST_TICKS:   cfg_d.selftest_ticks = wr_i.data[2:0];
        CFG_TRAVEL:     cfg_d.travel_limit = wr_i.data[7:0];
        CFG_NORM_STEP:  cfg_d.normal_step = wr_i.data[3:0];
        CFG_RED_STEP:   cfg_d.reduced_step = wr_i.data[3:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.emergency_power_max <= EmergPowerMaxRst;
      cfg_q.degraded_power_max  <= DegradedPowerMaxRst;
      cfg_q.selftest_ticks      <= SelftestTicksRst;
      cfg_q.travel_limit        <= TravelLimitRst;
      cfg_q.normal_step         <= NormalStepRst;
      cfg_q.reduced_step        <= ReducedStepRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/core/pds_fsm.sv
// supervisor and panel state machines of the panel deploy supervisor
`include "panel_deploy_supervisor_assert.svh"

module pds_fsm (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  pds_pkg::pds_item_t   item_i,
  input  pds_pkg::pds_cfg_t    cfg_i,
  output pds_pkg::pds_result_t res_o
);
  import pds_pkg::*;

  pds_state_e state_q, state_d;
  pds_pmode_e pmode_q, pmode_d;
  logic [7:0] pos_q, pos_d;
  logic [2:0] tick_q, tick_d;
  logic       reduced_q, reduced_d;
  logic       on_q, on_d;
  pds_event_e ev;

  logic [3:0] step;
  logic [8:0] pos_sum;
  logic [7:0] pos_ext;
  logic [2:0] tick_inc;

  assign step     = reduced_q ? cfg_i.reduced_step : cfg_i.normal_step;
  assign pos_sum  = {1'b0, pos_q} + {5'b0, step};
  assign pos_ext  = pos_sum[8] ? PosMax : pos_sum[7:0];
  assign tick_inc = (tick_q < TickMax) ? tick_q + 3'd1 : tick_q;

  // next state
  always_comb begin
    state_d   = state_q;
    pmode_d   = pmode_q;
    pos_d     = pos_q;
    tick_d    = tick_q;
    reduced_d = reduced_q;
    on_d      = item_i.on_write ? item_i.on_value : on_q;
    unique case (state_q)
      ST_EMERG: begin
        state_d = ST_STANDBY;
        on_d    = 1'b0;
      end
      ST_OPER: begin
        unique case (pmode_q)
          PM_EXTEND: begin
            pos_d = pos_ext;
            if (pos_ext >= cfg_i.travel_limit) pmode_d = PM_OPEN;
          end
          PM_RETRACT: begin
            if (pos_q <= {4'b0, step}) begin
              pos_d   = '0;
              pmode_d = PM_CLOSED;
            end else begin
              pos_d = pos_q - {4'b0, step};
            end
          end
          PM_CLOSED: if (item_i.panel_request) pmode_d = PM_EXTEND;
          PM_OPEN:   if (!item_i.panel_request) pmode_d = PM_RETRACT;
          default:   pos_d = '0;
        endcase
      end
      ST_STANDBY: begin
        if (on_d) begin
          state_d = ST_SELFTEST;
          tick_d  = '0;
        end
      end
      ST_SELFTEST: begin
        priority if (item_i.supply_power <= cfg_i.emergency_power_max) begin
          state_d = ST_EMERG;
        end else if (item_i.supply_power <= cfg_i.degraded_power_max) begin
          state_d = ST_FAIL;
        end else begin
          tick_d = tick_inc;
          if (tick_inc >= cfg_i.selftest_ticks) state_d = ST_READY;
        end
      end
      ST_FAIL: begin
        state_d   = ST_OPER;
        pmode_d   = PM_CLOSED;
        reduced_d = 1'b1;
      end
      ST_READY: state_d = item_i.maintenance_switch ? ST_MAINT : ST_OPER;
      default:  state_d = state_q;
    endcase
  end

  // event code
  always_comb begin
    ev = EV_NONE;
    unique case (state_q)
      ST_OPER: begin
        if (pmode_q == PM_RETRACT && pos_q <= {4'b0, step}) ev = EV_CLOSED;
        if (pmode_q == PM_OPEN && !item_i.panel_request) ev = EV_RETRACT;
      end
      ST_STANDBY: if (item_i.shutdown_switch) ev = EV_SHUTDOWN;
      ST_FAIL:    ev = EV_REDUCED;
      default:    ev = EV_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_STANDBY;
      pmode_q   <= PM_SAFE;
      pos_q     <= '0;
      tick_q    <= '0;
      reduced_q <= 1'b0;
      on_q      <= 1'b0;
    end else if (adv_i) begin
      state_q   <= state_d;
      pmode_q   <= pmode_d;
      pos_q     <= pos_d;
      tick_q    <= tick_d;
      reduced_q <= reduced_d;
      on_q      <= on_d;
    end
  end

  assign res_o.state_code     = state_d;
  assign res_o.panel_mode     = pmode_d;
  assign res_o.panel_position = pos_d;
  assign res_o.reduced_active = reduced_d;
  assign res_o.on_state       = on_d;
  assign res_o.event_code     = ev;

  `PDS_ASSERT_NEXT(a_maint_terminal, clk_i, rst_ni, state_q == ST_MAINT, state_q == ST_MAINT)
  `PDS_ASSERT_NEXT(a_reduced_sticky, clk_i, rst_ni, reduced_q, reduced_q)
  `PDS_ASSERT_NEXT(a_emerg_exit, clk_i, rst_ni, adv_i && state_q == ST_EMERG,
                   state_q == ST_STANDBY && !on_q)
  `PDS_ASSERT_SAME(a_pos_only_oper, clk_i, rst_ni, pos_q != 8'd0, state_q == ST_OPER)

endmodule

>>> rtl/core/panel_deploy_supervisor.sv
// top level of the panel deploy supervisor
// usage:
//   s_axis carries one evaluation tick per item; m_axis returns one result item
//   per tick, in order. the cfg channel writes the six threshold and step
//   registers by index; indexes past the last register are dropped. cfg_ready_o
//   is always high, and writes belong between runs of items.
// pipeline and throughput:
//   an accepted item is registered in the input register, evaluated by the state
//   machine, and its result moves to the output register when that is free.
//   one item per cycle is sustained while m_axis_tready is high; the rate is
//   set by the single state update between the input and output registers.
// reset:
//   rst_ni clears both pipeline stages, the supervisor returns to standby with
//   the panel in safe shutdown, and the registers take their default values.
// stall:
//   while m_axis_tready is low the result holds in the output register, one
//   more item waits in the input register, then s_axis_tready drops.
module panel_deploy_supervisor (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  // on_write, on_value, supply_power[15:0], maintenance_switch, shutdown_switch,
  // panel_request, zero pad
  input  logic [pds_pkg::InDataW-1:0]  s_axis_tdata,
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // state_code[2:0], panel_mode[2:0], panel_position[7:0], reduced_active,
  // on_state, event_code[2:0], zero pad
  output logic [pds_pkg::OutDataW-1:0] m_axis_tdata,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [pds_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [pds_pkg::CfgDataW-1:0] cfg_data_i
);
  import pds_pkg::*;

  logic        in_valid_q, in_valid_d;
  pds_item_t   in_item_q;
  logic        out_valid_q, out_valid_d;
  pds_result_t out_res_q;
  pds_result_t res;
  pds_cfg_t    cfg;
  pds_cfg_wr_t cfg_wr;
  logic        s_acc, adv;

  assign cfg_ready_o  = 1'b1;
  assign cfg_wr.valid = cfg_valid_i;
  assign cfg_wr.index = cfg_index_i;
  assign cfg_wr.data  = cfg_data_i;

  pds_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (cfg_wr),
    .cfg_o  (cfg)
  );

  assign adv           = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || adv;
  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign in_valid_d    = s_acc || (in_valid_q && !adv);
  assign out_valid_d   = adv || (out_valid_q && !m_axis_tready);

  pds_fsm u_fsm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .item_i (in_item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      in_item_q.on_write           <= s_axis_tdata[0];
      in_item_q.on_value           <= s_axis_tdata[1];
      in_item_q.supply_power       <= s_axis_tdata[17:2];
      in_item_q.maintenance_switch <= s_axis_tdata[18];
      in_item_q.shutdown_switch    <= s_axis_tdata[19];
      in_item_q.panel_request      <= s_axis_tdata[20];
    end
    if (adv) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b0, out_res_q.event_code, out_res_q.on_state,
                          out_res_q.reduced_active, out_res_q.panel_position,
                          out_res_q.panel_mode, out_res_q.state_code};

endmodule

>>> dv/panel_deploy_supervisor_tb.sv
// testbench for panel_deploy_supervisor: power-on, self-test, service entry and panel travel against a predictor
module panel_deploy_supervisor_tb;
  import pds_pkg::*;

  localparam int unsigned IdleLimit = 2000;
  localparam int unsigned DrainCycles = 4;
  localparam int unsigned PrintCap = 50;
  localparam logic [CfgIdxW-1:0] CfgSpareA = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgSpareB = 3'd7;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  // predicted supervisor state
  pds_cfg_t   sup_cfg;
  pds_state_e sup_state;
  pds_pmode_e sup_pmode;
  logic [7:0] sup_pos;
  logic [2:0] sup_ticks;
  logic       sup_reduced;
  logic       sup_on;

  pds_result_t expected_results[$];
  int unsigned err_cnt = 0;
  int unsigned idle_cycles = 0;
  int unsigned burst_left = 0;
  int unsigned rdy_run = 0;
  int unsigned rdy_mode = 0;
  logic        req_level = 1'b0;
  int unsigned req_dwell = 0;

  panel_deploy_supervisor dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic pds_result_t advance_supervisor(input pds_item_t t);
    pds_result_t r;
    pds_event_e  ev;
    logic [3:0]  step;
    logic [8:0]  sum;
    ev = EV_NONE;
    if (t.on_write) sup_on = t.on_value;
    case (sup_state)
      ST_EMERG: begin
        sup_state = ST_STANDBY;
        sup_on = 1'b0;
      end
      ST_OPER: begin
        step = sup_reduced ? sup_cfg.reduced_step : sup_cfg.normal_step;
        case (sup_pmode)
          PM_EXTEND: begin
            sum = {1'b0, sup_pos} + {5'd0, step};
            sup_pos = sum[8] ? PosMax : sum[7:0];
            if (sup_pos >= sup_cfg.travel_limit) sup_pmode = PM_OPEN;
          end
          PM_RETRACT: begin
            if (sup_pos <= {4'd0, step}) begin
              sup_pos = '0;
              sup_pmode = PM_CLOSED;
              ev = EV_CLOSED;
            end else begin
              sup_pos = sup_pos - {4'd0, step};
            end
          end
          PM_CLOSED: begin
            if (t.panel_request) sup_pmode = PM_EXTEND;
          end
          PM_OPEN: begin
            if (!t.panel_request) begin
              sup_pmode = PM_RETRACT;
              ev = EV_RETRACT;
            end
          end
          default: sup_pos = '0;
        endcase
      end
      ST_STANDBY: begin
        if (sup_on) begin
          sup_state = ST_SELFTEST;
          sup_ticks = '0;
        end
        if (t.shutdown_switch) ev = EV_SHUTDOWN;
      end
      ST_SELFTEST: begin
        if (t.supply_power <= sup_cfg.emergency_power_max) begin
          sup_state = ST_EMERG;
        end else if (t.supply_power <= sup_cfg.degraded_power_max) begin
          sup_state = ST_FAIL;
        end else begin
          if (sup_ticks < TickMax) sup_ticks = sup_ticks + 3'd1;
          if (sup_ticks >= sup_cfg.selftest_ticks) sup_state = ST_READY;
        end
      end
      ST_FAIL: begin
        sup_state = ST_OPER;
        sup_pmode = PM_CLOSED;
        sup_reduced = 1'b1;
        ev = EV_REDUCED;
      end
      ST_READY: begin
        sup_state = t.maintenance_switch ? ST_MAINT : ST_OPER;
      end
      default: ;
    endcase
    r.state_code = sup_state;
    r.panel_mode = sup_pmode;
    r.panel_position = sup_pos;
    r.reduced_active = sup_reduced;
    r.on_state = sup_on;
    r.event_code = ev;
    return r;
  endfunction

  function automatic void apply_reg_write(input logic [CfgIdxW-1:0] idx,
                                          input logic [CfgDataW-1:0] d);
    case (idx)
      CFG_EMERG_PMAX: sup_cfg.emergency_power_max = d;
      CFG_DEGR_PMAX:  sup_cfg.degraded_power_max = d;
      CFG_ST_TICKS:   sup_cfg.selftest_ticks = d[2:0];
      CFG_TRAVEL:     sup_cfg.travel_limit = d[7:0];
      CFG_NORM_STEP:  sup_cfg.normal_step = d[3:0];
      CFG_RED_STEP:   sup_cfg.reduced_step = d[3:0];
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (err_cnt < PrintCap) $display("mismatch %s: got %0d, expected %0d", what, got, want);
    err_cnt++;
  endtask

  always @(posedge clk_i) begin : check_results
    pds_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result with none pending", 32'(m_axis_tdata), 0);
      end else begin
        want = expected_results.pop_front();
        if (m_axis_tdata[2:0] != want.state_code)
          report_mismatch("state_code", 32'(m_axis_tdata[2:0]), 32'(want.state_code));
        if (m_axis_tdata[5:3] != want.panel_mode)
          report_mismatch("panel_mode", 32'(m_axis_tdata[5:3]), 32'(want.panel_mode));
        if (m_axis_tdata[13:6] != want.panel_position)
          report_mismatch("panel_position", 32'(m_axis_tdata[13:6]),
                          32'(want.panel_position));
        if (m_axis_tdata[14] != want.reduced_active)
          report_mismatch("reduced_active", 32'(m_axis_tdata[14]),
                          32'(want.reduced_active));
        if (m_axis_tdata[15] != want.on_state)
          report_mismatch("on_state", 32'(m_axis_tdata[15]), 32'(want.on_state));
        if (m_axis_tdata[18:16] != want.event_code)
          report_mismatch("event_code", 32'(m_axis_tdata[18:16]), 32'(want.event_code));
      end
    end
  end

  // result side back-pressure
  always @(posedge clk_i) begin
    if (rdy_run == 0) begin
      rdy_mode = $urandom_range(0, 3);
      rdy_run = $urandom_range(8, 64);
    end
    rdy_run--;
    case (rdy_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom);
      2: m_axis_tready <= ($urandom_range(0, 3) == 0);
      default: m_axis_tready <= (rdy_run < 6);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && !((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                    (cfg_valid_i && cfg_ready_o))) begin
      idle_cycles++;
    end else begin
      idle_cycles = 0;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_tick(input pds_item_t t);
    logic [InDataW-1:0] d;
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= InDataW'($urandom);
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    d = '0;
    d[0] = t.on_write;
    d[1] = t.on_value;
    d[17:2] = t.supply_power;
    d[18] = t.maintenance_switch;
    d[19] = t.shutdown_switch;
    d[20] = t.panel_request;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected_results.push_back(advance_supervisor(t));
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int unsigned width,
                           input logic [CfgDataW-1:0] value);
    logic [CfgDataW-1:0] mask;
    logic [CfgDataW-1:0] d;
    mask = CfgDataW'((32'd1 << width) - 1);
    d = (CfgDataW'($urandom) & ~mask) | (value & mask);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= d;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    apply_reg_write(idx, d);
  endtask

  task automatic load_settings(input pds_cfg_t s);
    drain_results();
    write_reg(CFG_EMERG_PMAX, 16, s.emergency_power_max);
    write_reg(CFG_DEGR_PMAX, 16, s.degraded_power_max);
    write_reg(CFG_ST_TICKS, 3, CfgDataW'(s.selftest_ticks));
    write_reg(CFG_TRAVEL, 8, CfgDataW'(s.travel_limit));
    write_reg(CFG_NORM_STEP, 4, CfgDataW'(s.normal_step));
    write_reg(CFG_RED_STEP, 4, CfgDataW'(s.reduced_step));
    // writes past the register list must leave everything alone
    write_reg(($urandom_range(0, 1) != 0) ? CfgSpareA : CfgSpareB, CfgDataW,
              CfgDataW'($urandom));
    cfg_valid_i <= 1'b0;
  endtask

  function automatic pds_cfg_t make_cfg(input logic [15:0] e, input logic [15:0] dg,
                                        input logic [2:0] k, input logic [7:0] tl,
                                        input logic [3:0] ns, input logic [3:0] rs);
    pds_cfg_t c;
    c.emergency_power_max = e;
    c.degraded_power_max = dg;
    c.selftest_ticks = k;
    c.travel_limit = tl;
    c.normal_step = ns;
    c.reduced_step = rs;
    return c;
  endfunction

  function automatic logic [15:0] pick16();
    case ($urandom_range(0, 4))
      0: return 16'd0;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_travel();
    case ($urandom_range(0, 4))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_power(input int unsigned lo, input int unsigned hi);
    case ($urandom_range(0, 5))
      0: return 16'(lo);
      1: return 16'(hi);
      default: return 16'($urandom_range(hi, lo));
    endcase
  endfunction

  function automatic pds_item_t make_tick(input logic ow, input logic ov, input logic [15:0] pw,
                                          input logic mt, input logic sd, input logic rq);
    pds_item_t t;
    t.on_write = ow;
    t.on_value = ov;
    t.supply_power = pw;
    t.maintenance_switch = mt;
    t.shutdown_switch = sd;
    t.panel_request = rq;
    return t;
  endfunction

  function automatic pds_item_t random_tick();
    return make_tick(1'($urandom), 1'($urandom), 16'($urandom), 1'($urandom), 1'($urandom),
                     1'($urandom));
  endfunction

  function automatic int unsigned good_power_floor();
    int unsigned e;
    int unsigned dg;
    e = 32'(sup_cfg.emergency_power_max);
    dg = 32'(sup_cfg.degraded_power_max);
    return ((e > dg) ? e : dg) + 1;
  endfunction

  // standby, self-test and emergency only; fail and ready are kept out
  function automatic pds_item_t selftest_cycle_tick();
    pds_item_t t;
    int unsigned good_lo;
    t = random_tick();
    good_lo = good_power_floor();
    case (sup_state)
      ST_STANDBY: begin
        if ($urandom_range(0, 9) < 7) begin
          t.on_write = 1'b1;
          t.on_value = 1'b1;
        end
      end
      ST_SELFTEST: begin
        if (good_lo <= 65535 && int'(sup_ticks) + 1 < int'(sup_cfg.selftest_ticks) &&
            $urandom_range(0, 9) < 7) begin
          t.supply_power = rand_power(good_lo, 65535);
        end else begin
          t.supply_power = rand_power(0, 32'(sup_cfg.emergency_power_max));
        end
      end
      default: ;
    endcase
    return t;
  endfunction

  function automatic pds_item_t service_tick(input pds_state_e via);
    pds_item_t t;
    t = random_tick();
    case (sup_state)
      ST_STANDBY: begin
        t.on_write = 1'b1;
        t.on_value = 1'b1;
      end
      ST_SELFTEST: begin
        if (via == ST_FAIL) begin
          t.supply_power = rand_power(int'(sup_cfg.emergency_power_max) + 1,
                                      32'(sup_cfg.degraded_power_max));
        end else begin
          t.supply_power = rand_power(good_power_floor(), 65535);
        end
      end
      ST_READY: t.maintenance_switch = (via == ST_MAINT);
      default: ;
    endcase
    return t;
  endfunction

  // request held until the panel settles, then flipped after a short dwell; one tick in five is fully random
  function automatic pds_item_t panel_tick();
    pds_item_t t;
    t = random_tick();
    if ($urandom_range(0, 4) == 0) return t;
    if ((sup_pmode == PM_OPEN && req_level) || (sup_pmode == PM_CLOSED && !req_level)) begin
      if (req_dwell == 0) begin
        req_level = !req_level;
        req_dwell = $urandom_range(0, 4);
      end else begin
        req_dwell--;
      end
    end
    t.panel_request = req_level;
    return t;
  endfunction

  task automatic test_power_on_sequence();
    int i;
    send_tick(make_tick(1'b0, 1'b0, 16'd0, 1'b0, 1'b0, 1'b0));
    send_tick(make_tick(1'b0, 1'b0, 16'hFFFF, 1'b0, 1'b1, 1'b0));
    send_tick(make_tick(1'b1, 1'b0, 16'hFFFF, 1'b1, 1'b0, 1'b1));
    // on and shutdown together
    send_tick(make_tick(1'b1, 1'b1, 16'd0, 1'b0, 1'b1, 1'b0));
    send_tick(make_tick(1'b0, 1'b0, 16'd501, 1'b1, 1'b1, 1'b1));
    send_tick(make_tick(1'b0, 1'b0, 16'hFFFF, 1'b0, 1'b0, 1'b0));
    send_tick(make_tick(1'b0, 1'b0, 16'd200, 1'b0, 1'b0, 1'b0));
    // emergency clears the on flag even when it is written
    send_tick(make_tick(1'b1, 1'b1, 16'd0, 1'b0, 1'b0, 1'b1));
    send_tick(make_tick(1'b0, 1'b0, 16'd0, 1'b0, 1'b0, 1'b0));
    send_tick(make_tick(1'b1, 1'b1, 16'hFFFF, 1'b0, 1'b0, 1'b0));
    send_tick(make_tick(1'b0, 1'b1, 16'd0, 1'b1, 1'b0, 1'b1));
    send_tick(make_tick(1'b0, 1'b0, 16'd0, 1'b0, 1'b1, 1'b0));
    send_tick(make_tick(1'b1, 1'b1, 16'd1000, 1'b0, 1'b0, 1'b0));
    // tick count restarts on re-entry
    for (i = 0; i < 4; i++) send_tick(make_tick(1'b0, 1'b0, 16'hFFFF, 1'b0, 1'b0, 1'b0));
    send_tick(make_tick(1'b1, 1'b0, 16'd0, 1'b1, 1'b1, 1'b1));
    send_tick(make_tick(1'b0, 1'b0, 16'd0, 1'b0, 1'b0, 1'b0));
  endtask

  task automatic test_selftest_cycles();
    int ph;
    int i;
    pds_cfg_t c;
    for (ph = 0; ph < 5; ph++) begin
      case (ph)
        0: c = make_cfg(16'hFFFF, 16'hFFFF, 3'd7, 8'd255, 4'd15, 4'd15);
        1: c = make_cfg(16'd0, 16'd0, 3'd7, 8'd0, 4'd0, 4'd0);
        2: c = make_cfg(16'd40000, 16'd100, 3'd4, 8'd1, 4'd1, 4'd1);
        default: c = make_cfg(pick16(), pick16(), 3'($urandom), pick_travel(), 4'($urandom),
                              4'($urandom));
      endcase
      load_settings(c);
      for (i = 0; i < 50; i++) send_tick(selftest_cycle_tick());
    end
  endtask

  task automatic test_enter_service();
    int unsigned pick;
    int unsigned e;
    pds_state_e via;
    pick = $urandom_range(0, 9);
    via = (pick == 0) ? ST_MAINT : (pick == 1) ? ST_OPER : ST_FAIL;
    e = $urandom_range(0, 60000);
    load_settings(make_cfg(16'(e), 16'($urandom_range(e + 1, 65534)), 3'($urandom),
                           8'd20, 4'd2, 4'd1));
    while (sup_state != ST_OPER && sup_state != ST_MAINT) send_tick(service_tick(via));
  endtask

  task automatic test_panel_travel();
    int ph;
    int i;
    int n;
    pds_cfg_t c;
    for (ph = 0; ph < 9; ph++) begin
      n = 50;
      case (ph)
        0: c = make_cfg(pick16(), pick16(), 3'd0, 8'd20, 4'd2, 4'd1);
        1: begin
          // overshoot past the top, then clamp on the way down
          c = make_cfg(pick16(), pick16(), 3'd1, 8'd255, 4'd15, 4'd13);
          n = 90;
        end
        2: c = make_cfg(pick16(), pick16(), 3'd7, 8'd0, 4'd0, 4'd15);
        3: c = make_cfg(pick16(), pick16(), 3'd3, 8'd15, 4'd15, 4'd15);
        4: begin
          c = make_cfg(pick16(), pick16(), 3'd2, 8'd200, 4'd0, 4'd0);
          n = 15;
        end
        5: c = make_cfg(pick16(), pick16(), 3'd6, 8'd1, 4'd1, 4'd1);
        default: c = make_cfg(pick16(), pick16(), 3'($urandom), pick_travel(), 4'($urandom),
                              4'($urandom_range(1, 15)));
      endcase
      load_settings(c);
      for (i = 0; i < n; i++) send_tick(panel_tick());
    end
  endtask

  initial begin
    sup_cfg = make_cfg(EmergPowerMaxRst, DegradedPowerMaxRst, SelftestTicksRst,
                       TravelLimitRst, NormalStepRst, ReducedStepRst);
    sup_state = ST_STANDBY;
    sup_pmode = PM_SAFE;
    sup_pos = '0;
    sup_ticks = '0;
    sup_reduced = 1'b0;
    sup_on = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_power_on_sequence();
    test_selftest_cycles();
    test_enter_service();
    test_panel_travel();
    drain_results();
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/pds_pkg.sv
rtl/core/pds_cfg.sv
rtl/core/pds_fsm.sv
rtl/core/panel_deploy_supervisor.sv
dv/panel_deploy_supervisor_tb.sv
